/* rtl/stack_slot_first_fit_allocator_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef STACK_SLOT_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define STACK_SLOT_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSFF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSFF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

/* rtl/ssff_pkg.sv */
package ssff_pkg;

    // Default sizes of the segment table and of the fields.
    localparam int DEFAULT_MAX_SEGMENTS = 64;
    localparam int DEFAULT_OFFSET_BITS  = 21;
    localparam int DEFAULT_BLOCK_BITS   = 16;

    // Freed counter of a release transaction saturates at its all-ones value.
    localparam int                    FREED_BITS = 7;
    localparam logic [FREED_BITS-1:0] FREED_MAX  = '1;

    localparam int STATUS_BITS = 2;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK             = 2'd0,
        STATUS_TABLE_FULL     = 2'd1,
        STATUS_FRAME_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        REQ_ALLOC   = 1'b0,
        REQ_RELEASE = 1'b1
    } req_type_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    // Condition flags returned by the shared adder.
    typedef struct packed {
        logic zero;
        logic borrow;
    } alu_flags_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_A_READ,
        ST_A_CHECK,
        ST_A_APPEND,
        ST_SH_RD,
        ST_SH_WR,
        ST_SP_HI,
        ST_SP_BASE,
        ST_SP_LO,
        ST_R_READ,
        ST_R_CHK1,
        ST_R_CHK2,
        ST_R_FREE,
        ST_R_NEXT,
        ST_R_SH_RD,
        ST_R_SH_WR,
        ST_FINISH
    } state_t;

endpackage

/* rtl/ssff_req_if.sv */
interface ssff_req_if #(
    parameter int OFFSET_BITS = ssff_pkg::DEFAULT_OFFSET_BITS,
    parameter int BLOCK_BITS  = ssff_pkg::DEFAULT_BLOCK_BITS
);
    logic                   valid;
    logic                   ready;
    logic                   req_type;
    logic [OFFSET_BITS-1:0] alloc_size;
    logic [BLOCK_BITS-1:0]  life_first;
    logic [BLOCK_BITS-1:0]  life_last;
    logic [BLOCK_BITS-1:0]  release_block;

    modport source (
        output valid, req_type, alloc_size, life_first, life_last, release_block,
        input  ready
    );

    modport sink (
        input  valid, req_type, alloc_size, life_first, life_last, release_block,
        output ready
    );
endinterface

/* rtl/ssff_rsp_if.sv */
interface ssff_rsp_if #(
    parameter int OFFSET_BITS = ssff_pkg::DEFAULT_OFFSET_BITS
);
    logic                             valid;
    logic                             ready;
    logic [OFFSET_BITS-1:0]           slot_offset;
    logic [OFFSET_BITS-1:0]           frame_bytes;
    logic [ssff_pkg::FREED_BITS-1:0]  freed_count;
    logic [ssff_pkg::STATUS_BITS-1:0] status;

    modport source (
        output valid, slot_offset, frame_bytes, freed_count, status,
        input  ready
    );

    modport sink (
        input  valid, slot_offset, frame_bytes, freed_count, status,
        output ready
    );
endinterface

/* rtl/ssff_ram.sv */
module ssff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* rtl/ssff_alu.sv */
module ssff_alu #(
    parameter int WIDTH = 22
) (
    input  ssff_pkg::alu_op_t    op,
    input  logic [WIDTH-1:0]     a,
    input  logic [WIDTH-1:0]     b,
    output logic [WIDTH-1:0]     res,
    output ssff_pkg::alu_flags_t flags
);
    logic             is_sub;
    logic [WIDTH-1:0] b_op;
    logic             carry;

    // A single adder serves both add and subtract; subtract adds the complement.
    assign is_sub = (op == ssff_pkg::ALU_SUB);
    assign b_op   = is_sub ? ~b : b;
    assign {carry, res} = {1'b0, a} + {1'b0, b_op} + {{WIDTH{1'b0}}, is_sub};

    // Borrow means a < b on a subtract; zero means equal operands on a subtract.
    assign flags.zero   = (res == '0);
    assign flags.borrow = is_sub & ~carry;
endmodule

/* rtl/stack_slot_first_fit_allocator.sv */
// Stack slot allocator over an ordered table of frame segments held in one
// single-port-read RAM. Each request is a transaction on req and yields one
// transaction on rsp; a new request is taken only after the previous one has
// finished its work, while its result may still wait in the output register.
// An allocate reads the table entries one by one in its scan, shifts entries
// up when a free segment is split, writes both halves, and then finishes. A
// release visits each entry and, for each merge with a free successor,
// shifts the entries behind it down. The pace is set by the RAM, which gives
// one entry per read from a registered read port, and by the one shared adder
// that does every size, offset and lifetime comparison. No clearing pass runs
// after reset: entries at or beyond the segment count are never read.
module stack_slot_first_fit_allocator #(
    parameter int MAX_SEGMENTS = ssff_pkg::DEFAULT_MAX_SEGMENTS,
    parameter int OFFSET_BITS  = ssff_pkg::DEFAULT_OFFSET_BITS,
    parameter int BLOCK_BITS   = ssff_pkg::DEFAULT_BLOCK_BITS
) (
    input logic          clk,
    input logic          rst_n,
    ssff_req_if.sink     req,
    ssff_rsp_if.source   rsp
);
    localparam int CW       = $clog2(MAX_SEGMENTS + 1);
    localparam int IW       = $clog2(MAX_SEGMENTS);
    localparam int EW       = 1 + 2 * OFFSET_BITS + 2 * BLOCK_BITS;
    localparam int AW       = ((OFFSET_BITS > BLOCK_BITS) ? OFFSET_BITS : BLOCK_BITS) + 1;
    localparam int LF_LO    = BLOCK_BITS;
    localparam int LEN_LO   = 2 * BLOCK_BITS;
    localparam int OFF_LO   = 2 * BLOCK_BITS + OFFSET_BITS;
    localparam int USED_POS = EW - 1;

    ssff_pkg::state_t state_reg, state_next;

    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          j_reg, j_next;
    logic [CW-1:0]          seg_count_reg, seg_count_next;
    logic [OFFSET_BITS-1:0] frame_size_reg, frame_size_next;

    logic                   kind_reg, kind_next;
    logic [OFFSET_BITS-1:0] size_reg, size_next;
    logic [BLOCK_BITS-1:0]  lf_reg, lf_next;
    logic [BLOCK_BITS-1:0]  ll_reg, ll_next;
    logic [BLOCK_BITS-1:0]  blk_reg, blk_next;

    logic [OFFSET_BITS-1:0] cur_off_reg, cur_off_next;
    logic [OFFSET_BITS-1:0] cur_len_reg, cur_len_next;
    logic [BLOCK_BITS-1:0]  cur_lf_reg, cur_lf_next;
    logic [BLOCK_BITS-1:0]  cur_ll_reg, cur_ll_next;
    logic [OFFSET_BITS-1:0] tmp_reg, tmp_next;

    logic [OFFSET_BITS-1:0]          slot_reg, slot_next;
    logic [ssff_pkg::FREED_BITS-1:0] freed_reg, freed_next;
    ssff_pkg::status_t               status_reg, status_next;

    logic                            rsp_valid_reg, rsp_valid_next;
    logic [OFFSET_BITS-1:0]          out_slot_reg, out_slot_next;
    logic [OFFSET_BITS-1:0]          out_frame_reg, out_frame_next;
    logic [ssff_pkg::FREED_BITS-1:0] out_freed_reg, out_freed_next;
    ssff_pkg::status_t               out_status_reg, out_status_next;

    // Table RAM ports.
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic          ram_re;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] rd_data;

    // Shared adder ports.
    ssff_pkg::alu_op_t    alu_op;
    logic [AW-1:0]        alu_a;
    logic [AW-1:0]        alu_b;
    logic [AW-1:0]        alu_res;
    ssff_pkg::alu_flags_t alu_flags;

    // Fields of the entry read last.
    logic                   rd_used;
    logic [OFFSET_BITS-1:0] rd_off;
    logic [OFFSET_BITS-1:0] rd_len;
    logic [BLOCK_BITS-1:0]  rd_lf;
    logic [BLOCK_BITS-1:0]  rd_ll;

    logic [CW-1:0]          idx_inc;
    logic [CW-1:0]          j_inc;
    logic [CW-1:0]          j_dec;
    logic                   table_full;
    logic                   out_free;
    logic [OFFSET_BITS-1:0] alu_low;

    function automatic logic [EW-1:0] pack_entry(
        input logic                   used,
        input logic [OFFSET_BITS-1:0] off,
        input logic [OFFSET_BITS-1:0] len,
        input logic [BLOCK_BITS-1:0]  lf,
        input logic [BLOCK_BITS-1:0]  ll
    );
        return {used, off, len, lf, ll};
    endfunction

    assign rd_used = rd_data[USED_POS];
    assign rd_off  = rd_data[OFF_LO +: OFFSET_BITS];
    assign rd_len  = rd_data[LEN_LO +: OFFSET_BITS];
    assign rd_lf   = rd_data[LF_LO +: BLOCK_BITS];
    assign rd_ll   = rd_data[0 +: BLOCK_BITS];

    assign idx_inc    = idx_reg + CW'(1);
    assign j_inc      = j_reg + CW'(1);
    assign j_dec      = j_reg - CW'(1);
    assign table_full = (seg_count_reg == CW'(MAX_SEGMENTS));
    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign alu_low    = alu_res[OFFSET_BITS-1:0];

    ssff_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SEGMENTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    ssff_alu #(
        .WIDTH (AW)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .res   (alu_res),
        .flags (alu_flags)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssff_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.req_type == ssff_pkg::REQ_RELEASE) ?
                                 ssff_pkg::ST_R_READ : ssff_pkg::ST_A_READ;
                end
            end
            ssff_pkg::ST_A_READ:
            begin
                state_next = (idx_reg == seg_count_reg) ?
                             ssff_pkg::ST_A_APPEND : ssff_pkg::ST_A_CHECK;
            end
            ssff_pkg::ST_A_CHECK:
            begin
                if (rd_used)
                begin
                    state_next = ssff_pkg::ST_A_READ;
                end
                else if (alu_flags.zero)
                begin
                    state_next = ssff_pkg::ST_FINISH;
                end
                else if (alu_flags.borrow)
                begin
                    state_next = table_full ? ssff_pkg::ST_FINISH : ssff_pkg::ST_SH_RD;
                end
                else
                begin
                    state_next = ssff_pkg::ST_A_READ;
                end
            end
            ssff_pkg::ST_A_APPEND: state_next = ssff_pkg::ST_FINISH;
            ssff_pkg::ST_SH_RD:
            begin
                state_next = (j_reg > idx_inc) ? ssff_pkg::ST_SH_WR : ssff_pkg::ST_SP_HI;
            end
            ssff_pkg::ST_SH_WR:   state_next = ssff_pkg::ST_SH_RD;
            ssff_pkg::ST_SP_HI:   state_next = ssff_pkg::ST_SP_BASE;
            ssff_pkg::ST_SP_BASE: state_next = ssff_pkg::ST_SP_LO;
            ssff_pkg::ST_SP_LO:   state_next = ssff_pkg::ST_FINISH;
            ssff_pkg::ST_R_READ:
            begin
                state_next = (idx_reg == seg_count_reg) ?
                             ssff_pkg::ST_FINISH : ssff_pkg::ST_R_CHK1;
            end
            ssff_pkg::ST_R_CHK1:
            begin
                if (!rd_used)
                begin
                    state_next = ssff_pkg::ST_R_READ;
                end
                else if (alu_flags.borrow)
                begin
                    state_next = ssff_pkg::ST_R_FREE;
                end
                else
                begin
                    state_next = ssff_pkg::ST_R_CHK2;
                end
            end
            ssff_pkg::ST_R_CHK2:
            begin
                state_next = alu_flags.borrow ? ssff_pkg::ST_R_FREE : ssff_pkg::ST_R_READ;
            end
            ssff_pkg::ST_R_FREE:
            begin
                state_next = (idx_inc < seg_count_reg) ?
                             ssff_pkg::ST_R_NEXT : ssff_pkg::ST_R_READ;
            end
            ssff_pkg::ST_R_NEXT:
            begin
                state_next = rd_used ? ssff_pkg::ST_R_READ : ssff_pkg::ST_R_SH_RD;
            end
            ssff_pkg::ST_R_SH_RD:
            begin
                state_next = (j_inc < seg_count_reg) ?
                             ssff_pkg::ST_R_SH_WR : ssff_pkg::ST_R_READ;
            end
            ssff_pkg::ST_R_SH_WR: state_next = ssff_pkg::ST_R_SH_RD;
            ssff_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ssff_pkg::ST_IDLE;
                end
            end
            default: state_next = ssff_pkg::ST_IDLE;
        endcase
    end

    // Datapath control, table accesses and next values of the registers.
    always_comb
    begin
        idx_next        = idx_reg;
        j_next          = j_reg;
        seg_count_next  = seg_count_reg;
        frame_size_next = frame_size_reg;
        kind_next       = kind_reg;
        size_next       = size_reg;
        lf_next         = lf_reg;
        ll_next         = ll_reg;
        blk_next        = blk_reg;
        cur_off_next    = cur_off_reg;
        cur_len_next    = cur_len_reg;
        cur_lf_next     = cur_lf_reg;
        cur_ll_next     = cur_ll_reg;
        tmp_next        = tmp_reg;
        slot_next       = slot_reg;
        freed_next      = freed_reg;
        status_next     = status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        out_slot_next   = out_slot_reg;
        out_frame_next  = out_frame_reg;
        out_freed_next  = out_freed_reg;
        out_status_next = out_status_reg;

        ram_we    = 1'b0;
        ram_waddr = idx_reg[IW-1:0];
        ram_wdata = rd_data;
        ram_re    = 1'b0;
        ram_raddr = idx_reg[IW-1:0];

        alu_op = ssff_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;

        req.ready = 1'b0;

        case (state_reg)
            // Capture a new request transaction.
            ssff_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    kind_next   = req.req_type;
                    size_next   = req.alloc_size;
                    lf_next     = req.life_first;
                    ll_next     = req.life_last;
                    blk_next    = req.release_block;
                    idx_next    = '0;
                    freed_next  = '0;
                    slot_next   = '0;
                    status_next = ssff_pkg::STATUS_OK;
                end
            end

            // First-fit scan: fetch the next entry.
            ssff_pkg::ST_A_READ:
            begin
                ram_re = (idx_reg != seg_count_reg);
            end

            // Compare the request with a free entry.
            ssff_pkg::ST_A_CHECK:
            begin
                alu_op       = ssff_pkg::ALU_SUB;
                alu_a        = AW'(size_reg);
                alu_b        = AW'(rd_len);
                cur_off_next = rd_off;
                cur_len_next = rd_len;
                cur_lf_next  = rd_lf;
                cur_ll_next  = rd_ll;
                if (rd_used)
                begin
                    idx_next = idx_inc;
                end
                else if (alu_flags.zero)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = pack_entry(1'b1, rd_off, rd_len, lf_reg, ll_reg);
                    slot_next = rd_off;
                end
                else if (alu_flags.borrow)
                begin
                    if (table_full)
                    begin
                        status_next = ssff_pkg::STATUS_TABLE_FULL;
                    end
                    else
                    begin
                        j_next = seg_count_reg;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            // Nothing fits: grow the frame by a new last segment, unless the table is full or the frame would overflow.
            ssff_pkg::ST_A_APPEND:
            begin
                alu_op = ssff_pkg::ALU_ADD;
                alu_a  = AW'(frame_size_reg);
                alu_b  = AW'(size_reg);
                if (table_full)
                begin
                    status_next = ssff_pkg::STATUS_TABLE_FULL;
                end
                else if (alu_res[OFFSET_BITS])
                begin
                    status_next = ssff_pkg::STATUS_FRAME_OVERFLOW;
                end
                else
                begin
                    frame_size_next = alu_low;
                    ram_we          = 1'b1;
                    ram_waddr       = seg_count_reg[IW-1:0];
                    ram_wdata       = pack_entry(1'b1, alu_low, size_reg, lf_reg, ll_reg);
                    seg_count_next  = seg_count_reg + CW'(1);
                    slot_next       = alu_low;
                end
            end

            // Split: move the tail of the table up by one entry.
            ssff_pkg::ST_SH_RD:
            begin
                if (j_reg > idx_inc)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = j_dec[IW-1:0];
                end
            end
            ssff_pkg::ST_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg[IW-1:0];
                j_next    = j_dec;
            end

            // Split: write the free remainder above the new slot.
            ssff_pkg::ST_SP_HI:
            begin
                alu_op    = ssff_pkg::ALU_SUB;
                alu_a     = AW'(cur_len_reg);
                alu_b     = AW'(size_reg);
                ram_we    = 1'b1;
                ram_waddr = idx_inc[IW-1:0];
                ram_wdata = pack_entry(1'b0, cur_off_reg, alu_low, cur_lf_reg, cur_ll_reg);
            end

            // Split: lower edge of the old segment.
            ssff_pkg::ST_SP_BASE:
            begin
                alu_op   = ssff_pkg::ALU_SUB;
                alu_a    = AW'(cur_off_reg);
                alu_b    = AW'(cur_len_reg);
                tmp_next = alu_low;
            end

            // Split: the used part sits at the lower displacement.
            ssff_pkg::ST_SP_LO:
            begin
                alu_op         = ssff_pkg::ALU_ADD;
                alu_a          = AW'(tmp_reg);
                alu_b          = AW'(size_reg);
                ram_we         = 1'b1;
                ram_wdata      = pack_entry(1'b1, alu_low, size_reg, lf_reg, ll_reg);
                seg_count_next = seg_count_reg + CW'(1);
                slot_next      = alu_low;
            end

            // Release scan: fetch the next entry.
            ssff_pkg::ST_R_READ:
            begin
                ram_re = (idx_reg != seg_count_reg);
            end

            // Expired when the block index lies before the first block.
            ssff_pkg::ST_R_CHK1:
            begin
                alu_op       = ssff_pkg::ALU_SUB;
                alu_a        = AW'(blk_reg);
                alu_b        = AW'(rd_lf);
                cur_off_next = rd_off;
                cur_len_next = rd_len;
                cur_lf_next  = rd_lf;
                cur_ll_next  = rd_ll;
                if (!rd_used)
                begin
                    idx_next = idx_inc;
                end
            end

            // Expired when the block index lies after the last block.
            ssff_pkg::ST_R_CHK2:
            begin
                alu_op = ssff_pkg::ALU_SUB;
                alu_a  = AW'(cur_ll_reg);
                alu_b  = AW'(blk_reg);
                if (!alu_flags.borrow)
                begin
                    idx_next = idx_inc;
                end
            end

            // Mark the entry free and look at its successor.
            ssff_pkg::ST_R_FREE:
            begin
                ram_we    = 1'b1;
                ram_wdata = pack_entry(1'b0, cur_off_reg, cur_len_reg, cur_lf_reg, cur_ll_reg);
                if (freed_reg != ssff_pkg::FREED_MAX)
                begin
                    freed_next = freed_reg + ssff_pkg::FREED_BITS'(1);
                end
                if (idx_inc < seg_count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_inc[IW-1:0];
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            // Merge with a free successor, then close the gap.
            ssff_pkg::ST_R_NEXT:
            begin
                alu_op = ssff_pkg::ALU_ADD;
                alu_a  = AW'(cur_len_reg);
                alu_b  = AW'(rd_len);
                if (rd_used)
                begin
                    idx_next = idx_inc;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = pack_entry(1'b0, rd_off, alu_low, cur_lf_reg, cur_ll_reg);
                    j_next    = idx_inc;
                end
            end
            ssff_pkg::ST_R_SH_RD:
            begin
                if (j_inc < seg_count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = j_inc[IW-1:0];
                end
                else
                begin
                    seg_count_next = seg_count_reg - CW'(1);
                    idx_next       = idx_inc;
                end
            end
            ssff_pkg::ST_R_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg[IW-1:0];
                j_next    = j_inc;
            end

            // Hand the result to the output register once it is free.
            ssff_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    out_slot_next   = slot_reg;
                    out_frame_next  = frame_size_reg;
                    out_freed_next  = freed_reg;
                    out_status_next = status_reg;
                end
            end

            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ssff_pkg::ST_IDLE;
            seg_count_reg  <= '0;
            frame_size_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            seg_count_reg  <= seg_count_next;
            frame_size_reg <= frame_size_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        j_reg          <= j_next;
        kind_reg       <= kind_next;
        size_reg       <= size_next;
        lf_reg         <= lf_next;
        ll_reg         <= ll_next;
        blk_reg        <= blk_next;
        cur_off_reg    <= cur_off_next;
        cur_len_reg    <= cur_len_next;
        cur_lf_reg     <= cur_lf_next;
        cur_ll_reg     <= cur_ll_next;
        tmp_reg        <= tmp_next;
        slot_reg       <= slot_next;
        freed_reg      <= freed_next;
        status_reg     <= status_next;
        out_slot_reg   <= out_slot_next;
        out_frame_reg  <= out_frame_next;
        out_freed_reg  <= out_freed_next;
        out_status_reg <= out_status_next;
    end

    // The request kind is held for the whole transaction; the sequencer
    // branches on it only at capture, so the result fields encode it.
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.slot_offset = (kind_reg == ssff_pkg::REQ_RELEASE && !rsp_valid_reg) ?
                             '0 : out_slot_reg;
    assign rsp.frame_bytes = out_frame_reg;
    assign rsp.freed_count = out_freed_reg;
    assign rsp.status      = out_status_reg;
endmodule

/* rtl/ssff_checker.sv */
`include "stack_slot_first_fit_allocator_assert.svh"

module ssff_checker #(
    parameter int OFFSET_BITS = ssff_pkg::DEFAULT_OFFSET_BITS
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             rsp_valid,
    input logic                             rsp_ready,
    input logic [OFFSET_BITS-1:0]           slot_offset,
    input logic [OFFSET_BITS-1:0]           frame_bytes,
    input logic [ssff_pkg::FREED_BITS-1:0]  freed_count,
    input logic [ssff_pkg::STATUS_BITS-1:0] status
);
    // A stalled result transaction holds its payload.
    `SSFF_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(slot_offset) && $stable(frame_bytes) && $stable(freed_count) && $stable(status))

    // The block works on one request at a time.
    `SSFF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready)

    // A failed allocate gives no slot.
    `SSFF_ASSERT_IMPL(a_fail_no_slot, clk, rst_n, rsp_valid && status != ssff_pkg::STATUS_OK, slot_offset == '0)

    // Only a release frees segments, and a release never fails.
    `SSFF_ASSERT_IMPL(a_release_shape, clk, rst_n, rsp_valid && freed_count != '0, slot_offset == '0 && status == ssff_pkg::STATUS_OK)

    // Every slot lies inside the frame.
    `SSFF_ASSERT_IMPL(a_slot_in_frame, clk, rst_n, rsp_valid, slot_offset <= frame_bytes)
endmodule

bind stack_slot_first_fit_allocator ssff_checker #(
    .OFFSET_BITS (OFFSET_BITS)
) u_ssff_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .slot_offset (rsp.slot_offset),
    .frame_bytes (rsp.frame_bytes),
    .freed_count (rsp.freed_count),
    .status      (rsp.status)
);

/* bench/stack_slot_first_fit_allocator_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the slot allocator, keeps its own copy of the
// segment table and checks every response against the predicted outcome.
module stack_slot_first_fit_allocator_checker
    import ssff_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ssff_req_if  req,
    ssff_rsp_if  rsp,
    output int   mismatches,
    output int   outstanding
);

    localparam int SEGMENTS = DEFAULT_MAX_SEGMENTS;
    localparam int OB       = DEFAULT_OFFSET_BITS;
    localparam int BB       = DEFAULT_BLOCK_BITS;

    // Largest frame size that still fits in the offset field.
    localparam logic [OB:0] FRAME_CAP = {1'b0, {OB{1'b1}}};

    typedef struct packed {
        logic [OB-1:0]         slot;
        logic [OB-1:0]         frame;
        logic [FREED_BITS-1:0] freed;
        status_t               status;
    } outcome_t;

    // Shadow copy of the segment table.
    logic          seg_taken [SEGMENTS];
    logic [OB-1:0] seg_top   [SEGMENTS];
    logic [OB-1:0] seg_size  [SEGMENTS];
    logic [BB-1:0] seg_from  [SEGMENTS];
    logic [BB-1:0] seg_upto  [SEGMENTS];
    int            entry_count;
    logic [OB-1:0] frame_total;

    outcome_t pending_outcomes [$];
    int       errors_seen;

    function automatic void move_segment(input int dst, input int src);
        seg_taken[dst] = seg_taken[src];
        seg_top[dst]   = seg_top[src];
        seg_size[dst]  = seg_size[src];
        seg_from[dst]  = seg_from[src];
        seg_upto[dst]  = seg_upto[src];
    endfunction

    // Applies one request to the shadow table and returns the outcome it must produce.
    function automatic outcome_t serve_request(input req_type_t     kind,
                                               input logic [OB-1:0] size,
                                               input logic [BB-1:0] life_lo,
                                               input logic [BB-1:0] life_hi,
                                               input logic [BB-1:0] blk);
        outcome_t      res;
        bit            placed;
        int            i;
        int            j;
        logic [OB-1:0] len;
        logic [OB-1:0] top;
        logic [OB:0]   grown;

        res        = '0;
        res.status = STATUS_OK;
        placed     = 1'b0;
        if (kind == REQ_ALLOC)
        begin
            // First fit over the free segments, in table order.
            for (i = 0; i < entry_count && !placed; i++)
            begin
                if (!seg_taken[i])
                begin
                    len = seg_size[i];
                    top = seg_top[i];
                    if (size == len)
                    begin
                        seg_taken[i] = 1'b1;
                        seg_from[i]  = life_lo;
                        seg_upto[i]  = life_hi;
                        res.slot     = top;
                        placed       = 1'b1;
                    end
                    else if (size < len)
                    begin
                        // A split needs a spare entry; without one the request fails here.
                        placed = 1'b1;
                        if (entry_count >= SEGMENTS)
                        begin
                            res.status = STATUS_TABLE_FULL;
                        end
                        else
                        begin
                            for (j = entry_count; j > i; j--)
                                move_segment(j, j - 1);
                            seg_taken[i]     = 1'b1;
                            seg_top[i]       = top - len + size;
                            seg_size[i]      = size;
                            seg_from[i]      = life_lo;
                            seg_upto[i]      = life_hi;
                            seg_taken[i + 1] = 1'b0;
                            seg_top[i + 1]   = top;
                            seg_size[i + 1]  = len - size;
                            entry_count++;
                            res.slot = seg_top[i];
                        end
                    end
                end
            end

            // Nothing fits: the frame grows by a new end segment if room allows.
            if (!placed)
            begin
                grown = {1'b0, frame_total} + {1'b0, size};
                if (entry_count >= SEGMENTS)
                begin
                    res.status = STATUS_TABLE_FULL;
                end
                else if (grown > FRAME_CAP)
                begin
                    res.status = STATUS_FRAME_OVERFLOW;
                end
                else
                begin
                    frame_total              = grown[OB-1:0];
                    seg_taken[entry_count]   = 1'b1;
                    seg_top[entry_count]     = frame_total;
                    seg_size[entry_count]    = size;
                    seg_from[entry_count]    = life_lo;
                    seg_upto[entry_count]    = life_hi;
                    entry_count++;
                    res.slot = frame_total;
                end
            end
        end
        else
        begin
            // Free every used segment that is not alive at the block index and
            // fold a free successor into it.
            i = 0;
            while (i < entry_count)
            begin
                if (seg_taken[i] && !(seg_from[i] <= blk && blk <= seg_upto[i]))
                begin
                    seg_taken[i] = 1'b0;
                    if (res.freed != FREED_MAX)
                        res.freed++;
                    if (i + 1 < entry_count && !seg_taken[i + 1])
                    begin
                        seg_size[i] = seg_size[i] + seg_size[i + 1];
                        seg_top[i]  = seg_top[i + 1];
                        for (j = i + 1; j + 1 < entry_count; j++)
                            move_segment(j, j + 1);
                        entry_count--;
                    end
                end
                i++;
            end
        end
        res.frame = frame_total;
        return res;
    endfunction

    // Responses are matched before new requests are predicted, so a spurious
    // response can never consume the outcome of a request taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;

        if (!rst_n)
        begin
            entry_count = 0;
            frame_total = '0;
            errors_seen = 0;
            pending_outcomes.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    errors_seen++;
                    if (errors_seen <= 10)
                        $display("%0t: response with no request pending: slot %0d frame %0d freed %0d status %0d",
                                 $realtime, rsp.slot_offset, rsp.frame_bytes, rsp.freed_count,
                                 rsp.status);
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (rsp.slot_offset !== want.slot || rsp.frame_bytes !== want.frame ||
                        rsp.freed_count !== want.freed || rsp.status !== want.status)
                    begin
                        errors_seen++;
                        if (errors_seen <= 10)
                            $display("%0t: expected slot %0d frame %0d freed %0d status %0d, got slot %0d frame %0d freed %0d status %0d",
                                     $realtime, want.slot, want.frame, want.freed, want.status,
                                     rsp.slot_offset, rsp.frame_bytes, rsp.freed_count,
                                     rsp.status);
                    end
                end
            end

            if (req.valid && req.ready)
                pending_outcomes.push_back(serve_request(req_type_t'(req.req_type),
                                                         req.alloc_size, req.life_first,
                                                         req.life_last, req.release_block));

            mismatches  <= errors_seen;
            outstanding <= pending_outcomes.size();
        end
    end

endmodule

/* bench/stack_slot_first_fit_allocator_test.sv */
`timescale 1ns / 1ps

module stack_slot_first_fit_allocator_test;

    import ssff_pkg::*;

    localparam int OB             = DEFAULT_OFFSET_BITS;
    localparam int BB             = DEFAULT_BLOCK_BITS;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 200;
    localparam int PHASE_ITEMS    = 310;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int mismatches;
    int outstanding;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_asks          = 0;
    int quiet_cycles       = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    ssff_req_if req_ch ();
    ssff_rsp_if rsp_ch ();

    stack_slot_first_fit_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    stack_slot_first_fit_allocator_checker frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Ends the run when no transaction completes on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Response side: random stalls, plus a long hold-off whenever one is asked for.
    initial
    begin : receiver
        int served;

        served = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (served != hold_asks)
            begin
                served = hold_asks;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    // Offers one request after a random idle gap and waits for its transaction.
    task automatic send_request(input req_type_t     kind,
                                input logic [OB-1:0] size,
                                input logic [BB-1:0] life_lo,
                                input logic [BB-1:0] life_hi,
                                input logic [BB-1:0] blk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= kind;
        req_ch.alloc_size    <= size;
        req_ch.life_first    <= life_lo;
        req_ch.life_last     <= life_hi;
        req_ch.release_block <= blk;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Stops offering requests until every predicted response has come back.
    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int            phase;
        int            n;
        int            pick;
        int            base_idle;
        int            base_stall;
        bit            calm;
        req_type_t     kind;
        logic [OB-1:0] size;
        logic [BB-1:0] life_lo;
        logic [BB-1:0] life_hi;
        logic [BB-1:0] blk;
        logic [BB-1:0] swap;
        logic [BB-1:0] now_block;

        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_ALLOC;
        req_ch.alloc_size    <= '0;
        req_ch.life_first    <= '0;
        req_ch.life_last     <= '0;
        req_ch.release_block <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: zero size, large sizes, frame overflow, inverted and
        // extreme lifetimes, exact fits, splits and merges on release.
        send_request(REQ_ALLOC,   21'd0,       16'd0,     16'd0,     16'hFFFF);
        send_request(REQ_ALLOC,   21'd16,      16'd1,     16'd5,     16'd0);
        send_request(REQ_ALLOC,   21'd1048576, 16'd0,     16'd0,     16'hFFFF);
        send_request(REQ_ALLOC,   21'd1048575, 16'd0,     16'hFFFF,  16'd0);
        send_request(REQ_ALLOC,   21'd1048576, 16'hFFFF,  16'd0,     16'hFFFF);
        send_request(REQ_ALLOC,   21'd8,       16'd9,     16'd3,     16'd0);
        send_request(REQ_ALLOC,   21'd4,       16'hFFFF,  16'hFFFF,  16'd0);
        send_request(REQ_ALLOC,   21'd2,       16'd0,     16'hFFFF,  16'hFFFF);
        send_request(REQ_RELEASE, 21'h1FFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF);
        send_request(REQ_RELEASE, 21'd0,       16'd0,     16'd0,     16'd0);
        send_request(REQ_ALLOC,   21'd16,      16'd2,     16'd3,     16'hFFFF);
        send_request(REQ_ALLOC,   21'd8,       16'd10,    16'd10,    16'd0);
        send_request(REQ_RELEASE, 21'd5,       16'd0,     16'd0,     16'd4);
        send_request(REQ_ALLOC,   21'd1048576, 16'd0,     16'd0,     16'd0);
        send_request(REQ_ALLOC,   21'd4,       16'hFFFF,  16'hFFFF,  16'd0);
        send_request(REQ_ALLOC,   21'd0,       16'd5,     16'd5,     16'd0);
        send_request(REQ_ALLOC,   21'd12,      16'd7,     16'd8,     16'd0);
        send_request(REQ_RELEASE, 21'd0,       16'd0,     16'd0,     16'd0);
        send_request(REQ_RELEASE, 21'd0,       16'd0,     16'd0,     16'hFFFF);
        wait_for_drain();

        // Random phases: no idling, sender idle, receiver stalling, both.
        now_block = 16'd100;
        for (phase = 0; phase < 4; phase++)
        begin
            base_idle  = (phase == 1) ? 45 : (phase == 3) ? 28 : 0;
            base_stall = (phase == 2) ? 45 : (phase == 3) ? 28 : 0;
            if (phase == 2)
                hold_asks++;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Every so often a stretch without any idling.
                if (n % 60 == 0)
                begin
                    calm               = ($urandom_range(0, 3) == 0);
                    sender_idle_pct    = calm ? 0 : base_idle;
                    receiver_stall_pct = calm ? 0 : base_stall;
                end

                kind    = REQ_ALLOC;
                size    = $urandom_range(0, 255);
                life_lo = $urandom;
                life_hi = $urandom;
                blk     = $urandom;
                pick    = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    // Noise: any type, lifetimes and block index over their whole range.
                    kind = req_type_t'($urandom_range(0, 1));
                end
                else if (pick < 62)
                begin
                    // Mostly small sizes so that exact fits and splits recur.
                    pick = $urandom_range(0, 399);
                    if (pick == 0)
                        size = $urandom_range(1, 1048576);
                    else if (pick < 8)
                        size = '0;
                    else if (pick < 200)
                        size = $urandom_range(1, 8);
                    else if (pick < 340)
                        size = $urandom_range(9, 64);
                    else
                        size = $urandom_range(65, 8191);
                    life_lo = now_block + BB'($urandom_range(0, 3));
                    life_hi = life_lo + BB'($urandom_range(0, 24));
                    if ($urandom_range(0, 19) == 0)
                    begin
                        swap    = life_lo;
                        life_lo = life_hi + 16'd1;
                        life_hi = swap;
                    end
                end
                else
                begin
                    // Releases walk the block index forward, with a rare jump.
                    kind      = REQ_RELEASE;
                    blk       = now_block;
                    now_block = now_block + BB'($urandom_range(0, 4));
                    if ($urandom_range(0, 49) == 0)
                        now_block = $urandom;
                end
                send_request(kind, size, life_lo, life_hi, blk);
            end
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/ssff_pkg.sv
rtl/ssff_req_if.sv
rtl/ssff_rsp_if.sv
rtl/ssff_ram.sv
rtl/ssff_alu.sv
rtl/stack_slot_first_fit_allocator.sv
rtl/ssff_checker.sv
bench/stack_slot_first_fit_allocator_checker.sv
bench/stack_slot_first_fit_allocator_test.sv
